[sv/rc5_pkg.sv]
// Package for the RC-5 infrared receiver: register indexes, reset values,
// packet field positions and the shared struct types.
// No dependencies.
package rc5_pkg;

	// Configuration register indexes
	localparam int CfgIndexBits = 3;
	localparam int CfgDataBits  = 16;

	typedef enum logic [CfgIndexBits-1:0] {
		CFG_QUARTER_BIT  = 3'd0,
		CFG_BIT_PERIOD   = 3'd1,
		CFG_LOCKOUT_UNIT = 3'd2,
		CFG_LOCKOUT_CNT  = 3'd3,
		CFG_DEVICE_ADDR  = 3'd4
	} cfg_idx_t;

	// Field widths of the packet and the registers
	localparam int TimeRegBits  = 16;
	localparam int UnitsBits    = 8;
	localparam int AddrBits     = 5;
	localparam int CmdBits      = 6;
	localparam int AddrLsb      = 6;

	// Register reset values
	localparam logic [TimeRegBits-1:0] QuarterBitReset  = 16'd444;
	localparam logic [TimeRegBits-1:0] BitPeriodReset   = 16'd1778;
	localparam logic [TimeRegBits-1:0] LockoutUnitReset = 16'd1000;
	localparam logic [UnitsBits-1:0]   LockoutCntReset  = 8'd50;
	localparam logic [AddrBits-1:0]    DeviceAddrReset  = 5'd21;

	// Input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Receiver phases, one-hot
	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_LOCKOUT = 5'b00010,
		PH_START1  = 5'b00100,
		PH_START2  = 5'b01000,
		PH_BITS    = 5'b10000
	} phase_t;

	// Register file contents handed to the receiver core
	typedef struct packed {
		logic [TimeRegBits-1:0] quarter_bit_ticks;
		logic [TimeRegBits-1:0] bit_period_ticks;
		logic [TimeRegBits-1:0] lockout_unit_ticks;
		logic [UnitsBits-1:0]   lockout_units;
		logic [AddrBits-1:0]    device_address;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [CmdBits-1:0] command_code;
		logic               packet_waiting;
		logic               receiver_busy;
	} result_t;

endpackage

[sv/rc5_item_if.sv]
// Input channel of the RC-5 receiver: opcode and pin sample per item.
// No dependencies.
interface rc5_item_if;
	logic valid;
	logic ready;
	logic opcode;
	logic pin_level;

	modport source (output valid, output opcode, output pin_level, input ready);
	modport sink (input valid, input opcode, input pin_level, output ready);
endinterface

[sv/rc5_result_if.sv]
// Result channel of the RC-5 receiver: command code and status per item.
// Depends on rc5_pkg for field widths.
interface rc5_result_if;
	logic                         valid;
	logic                         ready;
	logic [rc5_pkg::CmdBits-1:0]  command_code;
	logic                         packet_waiting;
	logic                         receiver_busy;

	modport source (output valid, output command_code, output packet_waiting,
		output receiver_busy, input ready);
	modport sink (input valid, input command_code, input packet_waiting,
		input receiver_busy, output ready);
endinterface

[sv/rc5_cfg_regs.sv]
// Configuration register file of the RC-5 receiver.
// Depends on rc5_pkg for register indexes, reset values and cfg_t.
module rc5_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [rc5_pkg::CfgIndexBits-1:0]  cfg_index,
	input  logic [rc5_pkg::CfgDataBits-1:0]   cfg_data,
	output rc5_pkg::cfg_t                     cfg
);

	rc5_pkg::cfg_t cfg_q;

	// Write the addressed register, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quarter_bit_ticks  <= rc5_pkg::QuarterBitReset;
			cfg_q.bit_period_ticks   <= rc5_pkg::BitPeriodReset;
			cfg_q.lockout_unit_ticks <= rc5_pkg::LockoutUnitReset;
			cfg_q.lockout_units      <= rc5_pkg::LockoutCntReset;
			cfg_q.device_address     <= rc5_pkg::DeviceAddrReset;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				rc5_pkg::CFG_QUARTER_BIT:  cfg_q.quarter_bit_ticks  <= cfg_data;
				rc5_pkg::CFG_BIT_PERIOD:   cfg_q.bit_period_ticks   <= cfg_data;
				rc5_pkg::CFG_LOCKOUT_UNIT: cfg_q.lockout_unit_ticks <= cfg_data;
				rc5_pkg::CFG_LOCKOUT_CNT:
					cfg_q.lockout_units <= cfg_data[rc5_pkg::UnitsBits-1:0];
				rc5_pkg::CFG_DEVICE_ADDR:
					cfg_q.device_address <= cfg_data[rc5_pkg::AddrBits-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/rc5_rx_core.sv]
// Receiver state of the RC-5 receiver: sampling timer, start-bit checks,
// bit shifter, held packet and lockout; computes one result per step.
// Depends on rc5_pkg for phases, cfg_t and result_t.
module rc5_rx_core #(
	parameter int PACKET_BITS = 12,
	parameter int TIMER_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rc5_pkg::cfg_t     cfg,
	input  logic              step,
	input  logic              opcode,
	input  logic              pin_level,
	output rc5_pkg::result_t  res
);

	localparam int BitIdxBits = $clog2(PACKET_BITS + 1);

	rc5_pkg::phase_t          phase_q, phase_d;
	logic [PACKET_BITS-1:0]   shift_q, shift_d;
	logic [PACKET_BITS-1:0]   held_q, held_d;
	logic                     held_valid_q, held_valid_d;
	logic [rc5_pkg::UnitsBits-1:0] lockout_q, lockout_d;
	logic [TIMER_BITS-1:0]    tick_q, tick_d;
	logic                     last_pin_q, last_pin_d;
	logic [BitIdxBits-1:0]    bit_q, bit_d;

	logic [TIMER_BITS-1:0]    target;
	logic [TIMER_BITS-1:0]    tick_inc;
	logic                     fire;
	logic [PACKET_BITS-1:0]   shift_nx;
	logic [BitIdxBits-1:0]    bit_nx;
	logic                     addr_match;

	// Select the timer target for the current phase
	always_comb begin
		priority if (phase_q == rc5_pkg::PH_START1)
			target = TIMER_BITS'(cfg.quarter_bit_ticks);
		else if (phase_q == rc5_pkg::PH_LOCKOUT)
			target = TIMER_BITS'(cfg.lockout_unit_ticks);
		else
			target = TIMER_BITS'(cfg.bit_period_ticks);
	end

	assign tick_inc = tick_q + TIMER_BITS'(1);
	assign fire     = (tick_inc >= target);
	assign shift_nx = {shift_q[PACKET_BITS-2:0], ~pin_level};
	assign bit_nx   = bit_q + BitIdxBits'(1);
	assign addr_match = (held_q[rc5_pkg::AddrLsb +: rc5_pkg::AddrBits] == cfg.device_address);

	// Next state for one item
	always_comb begin
		phase_d      = phase_q;
		shift_d      = shift_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		lockout_d    = lockout_q;
		tick_d       = tick_q;
		last_pin_d   = last_pin_q;
		bit_d        = bit_q;
		if (step) begin
			if (opcode == rc5_pkg::OP_FETCH) begin
				held_d       = '0;
				held_valid_d = 1'b0;
			end else begin
				last_pin_d = pin_level;
				if (phase_q == rc5_pkg::PH_IDLE) begin
					// Start on a falling edge
					if (last_pin_q && !pin_level) begin
						phase_d = rc5_pkg::PH_START1;
						tick_d  = '0;
					end
				end else begin
					tick_d = tick_inc;
					if (fire) begin
						tick_d = '0;
						unique case (phase_q)
							rc5_pkg::PH_LOCKOUT: begin
								if (lockout_q != '0)
									lockout_d = lockout_q - rc5_pkg::UnitsBits'(1);
								if (lockout_q <= rc5_pkg::UnitsBits'(1))
									phase_d = rc5_pkg::PH_IDLE;
							end
							rc5_pkg::PH_START1: begin
								if (!pin_level) begin
									phase_d = rc5_pkg::PH_START2;
								end else begin
									phase_d   = rc5_pkg::PH_LOCKOUT;
									lockout_d = cfg.lockout_units;
								end
							end
							rc5_pkg::PH_START2: begin
								if (!pin_level) begin
									phase_d = rc5_pkg::PH_BITS;
									bit_d   = '0;
									shift_d = '0;
								end else begin
									phase_d   = rc5_pkg::PH_LOCKOUT;
									lockout_d = cfg.lockout_units;
								end
							end
							rc5_pkg::PH_BITS: begin
								shift_d = shift_nx;
								bit_d   = bit_nx;
								// Hold the packet after its last bit
								if (bit_nx >= BitIdxBits'(PACKET_BITS)) begin
									held_d       = shift_nx;
									held_valid_d = 1'b1;
									bit_d        = '0;
									phase_d      = rc5_pkg::PH_LOCKOUT;
									lockout_d    = cfg.lockout_units;
								end
							end
							default: ;
						endcase
					end
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rc5_pkg::PH_IDLE;
			shift_q      <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			lockout_q    <= '0;
			tick_q       <= '0;
			last_pin_q   <= 1'b1;
			bit_q        <= '0;
		end else begin
			phase_q      <= phase_d;
			shift_q      <= shift_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			lockout_q    <= lockout_d;
			tick_q       <= tick_d;
			last_pin_q   <= last_pin_d;
			bit_q        <= bit_d;
		end
	end

	// Result: command on a matching fetch, status after the step
	always_comb begin
		res.command_code = '0;
		if (opcode == rc5_pkg::OP_FETCH && addr_match)
			res.command_code = held_q[rc5_pkg::CmdBits-1:0];
		res.packet_waiting = held_valid_d;
		res.receiver_busy  = (phase_d != rc5_pkg::PH_IDLE);
	end

	// An empty slot holds the zero packet
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!held_valid_q |-> held_q == '0)
		else $error("held packet not cleared while empty");

	// The timer rests at zero in idle
	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rc5_pkg::PH_IDLE |-> tick_q == '0)
		else $error("timer running in idle");

	// Bit index only moves while shifting bits
	a_bit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != rc5_pkg::PH_BITS |-> bit_q == '0)
		else $error("bit index nonzero outside bit phase");

	// A fetch empties the slot
	a_fetch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && opcode == rc5_pkg::OP_FETCH |=> !held_valid_q)
		else $error("packet still held after fetch");

endmodule

[sv/rc5_ir_receiver.sv]
// RC-5 infrared receiver with built-in sampling timer.
// An accepted item passes the input register, then the receiver state and the
// result register; it waits in the input register while the result is not taken.
// Throughput: one item per cycle while the result side takes each result.
// Reset: asynchronous, active low; restores register defaults, idle phase,
// no packet held, pin assumed high.
module rc5_ir_receiver #(
	parameter int PACKET_BITS = 12,
	parameter int TIMER_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rc5_item_if.sink                          rx_item,
	rc5_result_if.source                      rx_result,
	input  logic                              cfg_wen,
	input  logic [rc5_pkg::CfgIndexBits-1:0]  cfg_index,
	input  logic [rc5_pkg::CfgDataBits-1:0]   cfg_data
);

	rc5_pkg::cfg_t    cfg;
	rc5_pkg::result_t res;
	rc5_pkg::result_t res_q;

	logic valid_s1;
	logic opcode_s1;
	logic pin_s1;
	logic out_valid_q;
	logic advance;
	logic step;

	rc5_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance when the result register is free or being taken
	assign advance = !out_valid_q || rx_result.ready;
	assign step    = valid_s1 && advance;
	assign rx_item.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_item.ready) begin
			valid_s1 <= rx_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_item.valid && rx_item.ready) begin
			opcode_s1 <= rx_item.opcode;
			pin_s1    <= rx_item.pin_level;
		end
	end

	rc5_rx_core #(
		.PACKET_BITS (PACKET_BITS),
		.TIMER_BITS  (TIMER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.opcode    (opcode_s1),
		.pin_level (pin_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign rx_result.valid          = out_valid_q;
	assign rx_result.command_code   = res_q.command_code;
	assign rx_result.packet_waiting = res_q.packet_waiting;
	assign rx_result.receiver_busy  = res_q.receiver_busy;

endmodule

[sim/tb_rc5_ir_receiver.sv]
// Testbench for rc5_ir_receiver: drives pin samples and fetches, predicts each status item.
// Checks every result field against its own model of the receiver timer and decoder.
// Depends on rc5_pkg, rc5_item_if, rc5_result_if and rc5_ir_receiver.
`timescale 1ns / 100ps

module tb_rc5_ir_receiver;
	import rc5_pkg::*;

	localparam int PacketBits    = 12;
	localparam int HoldOffCycles = 200;
	localparam int QuietLimit    = 2000;
	localparam logic [CfgIndexBits-1:0] CfgFirstUnused = CfgIndexBits'(CFG_DEVICE_ADDR + 1);

	typedef struct packed {
		logic opcode;
		logic pin_level;
	} ir_item_t;

	typedef enum {
		FRAME_CLEAN,
		FRAME_BAD_START1,
		FRAME_BAD_START2,
		FRAME_CUT
	} frame_flaw_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CfgIndexBits-1:0] cfg_index;
	logic [CfgDataBits-1:0] cfg_data;

	rc5_item_if   item_ch ();
	rc5_result_if result_ch ();

	rc5_ir_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_item   (item_ch.sink),
		.rx_result (result_ch.source),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies
	logic [TimeRegBits-1:0] quarter_ticks;
	logic [TimeRegBits-1:0] period_ticks;
	logic [TimeRegBits-1:0] unit_ticks;
	logic [UnitsBits-1:0]   lockout_units_cfg;
	logic [AddrBits-1:0]    dev_addr;

	// Receiver state copies
	phase_t                  rx_phase;
	logic [PacketBits-1:0]   rx_shift;
	logic [PacketBits-1:0]   rx_held;
	logic                    rx_held_valid;
	logic [UnitsBits-1:0]    rx_units_left;
	logic [TimeRegBits-1:0]  rx_ticks;
	logic                    rx_last_pin;
	int                      rx_bit_idx;

	ir_item_t ir_samples_q[$];
	result_t  receiver_status_q[$];
	ir_item_t next_sample;

	int send_idle_pct = 35;
	int recv_idle_pct = 53;
	int hold_asked    = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	int queued_items    = 0;
	int frames_sent     = 0;
	int frames_clean    = 0;
	int fetches_sent    = 0;
	int config_rounds   = 0;
	int results_checked = 0;
	int mismatches      = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic note_mismatch(string field, logic [7:0] got, logic [7:0] want);
		$display("%0t: %s differs on result %0d: got %0h, expected %0h",
			$time, field, results_checked, got, want);
		mismatches++;
	endtask

	function automatic void start_lockout();
		rx_phase = PH_LOCKOUT;
		rx_units_left = lockout_units_cfg;
		rx_ticks = '0;
	endfunction

	// Advance the receiver copy by one item and return the status it reports
	function automatic result_t advance_receiver(logic op, logic pin);
		result_t r;
		logic [TimeRegBits-1:0] target;
		r = '0;
		if (op == OP_FETCH) begin
			if (rx_held[AddrLsb +: AddrBits] == dev_addr)
				r.command_code = rx_held[CmdBits-1:0];
			rx_held = '0;
			rx_held_valid = 1'b0;
		end else begin
			if (rx_phase == PH_IDLE) begin
				if (rx_last_pin && !pin) begin
					rx_phase = PH_START1;
					rx_ticks = '0;
				end
			end else begin
				case (rx_phase)
					PH_START1:  target = quarter_ticks;
					PH_LOCKOUT: target = unit_ticks;
					default:    target = period_ticks;
				endcase
				rx_ticks = rx_ticks + TimeRegBits'(1);
				if (rx_ticks >= target) begin
					rx_ticks = '0;
					case (rx_phase)
						PH_LOCKOUT: begin
							if (rx_units_left != 0)
								rx_units_left = rx_units_left - UnitsBits'(1);
							if (rx_units_left == 0)
								rx_phase = PH_IDLE;
						end
						PH_START1: begin
							if (!pin)
								rx_phase = PH_START2;
							else
								start_lockout();
						end
						PH_START2: begin
							if (!pin) begin
								rx_phase = PH_BITS;
								rx_bit_idx = 0;
								rx_shift = '0;
							end else begin
								start_lockout();
							end
						end
						PH_BITS: begin
							rx_shift = {rx_shift[PacketBits-2:0], ~pin};
							rx_bit_idx++;
							if (rx_bit_idx >= PacketBits) begin
								rx_held = rx_shift;
								rx_held_valid = 1'b1;
								rx_bit_idx = 0;
								start_lockout();
							end
						end
						default: ;
					endcase
				end
			end
			rx_last_pin = pin;
		end
		r.packet_waiting = rx_held_valid;
		r.receiver_busy = (rx_phase != PH_IDLE);
		return r;
	endfunction

	// Drive items from the pending queue; predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.opcode <= OP_TICK;
			item_ch.pin_level <= 1'b1;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				receiver_status_q.push_back(advance_receiver(item_ch.opcode, item_ch.pin_level));
				if (item_ch.opcode == OP_FETCH)
					fetches_sent++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (ir_samples_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_sample = ir_samples_q.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.opcode <= next_sample.opcode;
					item_ch.pin_level <= next_sample.pin_level;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Check each status item against the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (receiver_status_q.size() == 0) begin
					note_mismatch("unexpected item", 8'(result_ch.command_code), 8'h0);
				end else begin
					if (result_ch.command_code !== receiver_status_q[0].command_code)
						note_mismatch("command_code", 8'(result_ch.command_code),
							8'(receiver_status_q[0].command_code));
					if (result_ch.packet_waiting !== receiver_status_q[0].packet_waiting)
						note_mismatch("packet_waiting", 8'(result_ch.packet_waiting),
							8'(receiver_status_q[0].packet_waiting));
					if (result_ch.receiver_busy !== receiver_status_q[0].receiver_busy)
						note_mismatch("receiver_busy", 8'(result_ch.receiver_busy),
							8'(receiver_status_q[0].receiver_busy));
					void'(receiver_status_q.pop_front());
				end
				results_checked++;
			end
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HoldOffCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("Timeout: no item moved for %0d cycles", QuietLimit);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_item(logic op, logic pin);
		ir_samples_q.push_back('{opcode: op, pin_level: pin});
		queued_items++;
	endtask

	// Wait until every item is sent and every status item checked
	task automatic wait_settled();
		@(negedge clk);
		while (ir_samples_q.size() != 0 || item_ch.valid || receiver_status_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_QUARTER_BIT:  quarter_ticks = data;
			CFG_BIT_PERIOD:   period_ticks = data;
			CFG_LOCKOUT_UNIT: unit_ticks = data;
			CFG_LOCKOUT_CNT:  lockout_units_cfg = data[UnitsBits-1:0];
			CFG_DEVICE_ADDR:  dev_addr = data[AddrBits-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Write all five registers; narrow ones get random upper bits
	task automatic configure(int q, int p, int unit, int units, int addr);
		logic [CfgDataBits-1:0] junk;
		junk = CfgDataBits'($urandom);
		write_reg(CFG_QUARTER_BIT, CfgDataBits'(q));
		write_reg(CFG_BIT_PERIOD, CfgDataBits'(p));
		write_reg(CFG_LOCKOUT_UNIT, CfgDataBits'(unit));
		write_reg(CFG_LOCKOUT_CNT, {junk[CfgDataBits-1:UnitsBits], 8'(units)});
		write_reg(CFG_DEVICE_ADDR, {junk[CfgDataBits-1:AddrBits], 5'(addr)});
		config_rounds++;
	endtask

	// Queue one frame at the current timing: lead-in high, start edge, then samples
	task automatic queue_frame(logic [PacketBits-1:0] bits, frame_flaw_t flaw);
		int q;
		int p;
		int span;
		int last_t;
		int k;
		logic [PacketBits+1:0] levels;
		logic lvl;
		q = int'(quarter_ticks);
		p = int'(period_ticks);
		span = q + (PacketBits + 1) * p;
		levels = {2'b00, ~bits};
		last_t = span;
		case (flaw)
			FRAME_BAD_START1: begin
				levels[PacketBits+1] = 1'b1;
				last_t = q;
			end
			FRAME_BAD_START2: begin
				levels[PacketBits] = 1'b1;
				last_t = q + p;
			end
			FRAME_CUT: last_t = $urandom_range(q + p + 1, span - 1);
			default: ;
		endcase
		// hold the pin high long enough for any lockout to run out
		repeat (int'(lockout_units_cfg) * int'(unit_ticks) + $urandom_range(1, 3))
			queue_item(OP_TICK, 1'b1);
		queue_item(OP_TICK, 1'b0);
		for (int t = 1; t <= last_t; t++) begin
			k = (t <= q) ? 0 : (t - q + p - 1) / p;
			lvl = levels[PacketBits + 1 - k];
			// jitter the pin away from the sample points
			if (t != q + k * p && $urandom_range(0, 3) == 0)
				lvl = ~lvl;
			queue_item(OP_TICK, lvl);
			if ($urandom_range(0, 39) == 0)
				queue_item(OP_FETCH, 1'($urandom_range(0, 1)));
		end
		// a cut frame still runs out its bit slots
		if (flaw == FRAME_CUT)
			repeat (span - last_t) queue_item(OP_TICK, 1'b1);
		frames_sent++;
		if (flaw == FRAME_CLEAN)
			frames_clean++;
	endtask

	// Random traffic: mostly frames with random content, some noise and broken frames
	task automatic run_phase(int n_items, bit pause_midway);
		int goal;
		int half;
		logic [PacketBits-1:0] bits;
		frame_flaw_t flaw;
		goal = queued_items + n_items;
		half = queued_items + n_items / 2;
		while (queued_items < goal) begin
			if (pause_midway && queued_items >= half) begin
				pause_midway = 1'b0;
				wait_settled();
			end
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(3, 10)) queue_item(OP_TICK, 1'($urandom_range(0, 1)));
				repeat (int'(quarter_ticks) + (PacketBits + 1) * int'(period_ticks)
						+ int'(lockout_units_cfg) * int'(unit_ticks))
					queue_item(OP_TICK, 1'b1);
			end
			bits = PacketBits'($urandom);
			if ($urandom_range(0, 2) != 0)
				bits[AddrLsb +: AddrBits] = dev_addr;
			case ($urandom_range(0, 7))
				0:       flaw = FRAME_BAD_START1;
				1:       flaw = FRAME_BAD_START2;
				2:       flaw = FRAME_CUT;
				default: flaw = FRAME_CLEAN;
			endcase
			queue_frame(bits, flaw);
			if ($urandom_range(0, 1) != 0)
				queue_item(OP_FETCH, 1'($urandom_range(0, 1)));
		end
		wait_settled();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		quarter_ticks = QuarterBitReset;
		period_ticks = BitPeriodReset;
		unit_ticks = LockoutUnitReset;
		lockout_units_cfg = LockoutCntReset;
		dev_addr = DeviceAddrReset;
		rx_phase = PH_IDLE;
		rx_shift = '0;
		rx_held = '0;
		rx_held_valid = 1'b0;
		rx_units_left = '0;
		rx_ticks = '0;
		rx_last_pin = 1'b1;
		rx_bit_idx = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: empty fetch, fetch keeps the last pin, edges ignored while receiving
		queue_item(OP_FETCH, 1'b0);
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_FETCH, 1'b0);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_TICK, 1'b0);
		wait_settled();

		// Shortest timing: the waiting start bit has already passed its count
		configure(1, 1, 1, 1, 0);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b0);
		for (int i = PacketBits - 1; i >= 0; i--)
			queue_item(OP_TICK, (i < CmdBits) ? 1'b0 : 1'b1);
		queue_item(OP_TICK, 1'b1);
		queue_item(OP_FETCH, 1'b1);
		queue_item(OP_FETCH, 1'b0);
		wait_settled();

		// Longest timing: start a frame and leave it counting
		configure(16'hffff, 16'hffff, 16'hffff, 8'hff, 5'h1f);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b0);
		queue_item(OP_TICK, 1'b1);
		wait_settled();

		// Writes to unused indexes must change nothing
		for (int i = CfgFirstUnused; i < (1 << CfgIndexBits); i++)
			write_reg(CfgIndexBits'(i), CfgDataBits'($urandom));

		configure($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
			$urandom_range(1, 4), $urandom_range(0, 31));
		run_phase(180, 1'b0);

		send_idle_pct = 53;
		recv_idle_pct = 35;
		configure($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
			$urandom_range(1, 4), $urandom_range(0, 31));
		run_phase(180, 1'b1);

		// No idling; hold the result side off so the block backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
			$urandom_range(1, 4), $urandom_range(0, 31));
		hold_asked++;
		run_phase(180, 1'b0);

		configure($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
			$urandom_range(1, 4), $urandom_range(0, 31));
		run_phase(180, 1'b0);

		wait_settled();
		repeat (8) @(posedge clk);
		$display("Covered %0d frames (%0d well-formed) and %0d fetches across %0d register settings;",
			frames_sent, frames_clean, fetches_sent, config_rounds);
		$display("%0d status items checked, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[rc5_ir_receiver.f]
sv/rc5_pkg.sv
sv/rc5_item_if.sv
sv/rc5_result_if.sv
sv/rc5_cfg_regs.sv
sv/rc5_rx_core.sv
sv/rc5_ir_receiver.sv
sim/tb_rc5_ir_receiver.sv
